>>> src/epsm_pkg.sv
package epsm_pkg;

    localparam int AVG_SAMPLES = 40;
    localparam int PERIOD_BITS = 24;

    localparam int CNT_W     = 16;
    localparam int SUM_W     = PERIOD_BITS + $clog2(AVG_SAMPLES);
    localparam int ACC_W     = (SUM_W > CNT_W) ? SUM_W : CNT_W;
    localparam int BAND_W    = PERIOD_BITS + 2;
    localparam int THR_W     = PERIOD_BITS + 2;
    localparam int PCT_W     = 8;
    localparam int PROD_W    = PERIOD_BITS + PCT_W;
    localparam int PCT_BASE  = 100;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int AVG_SHIFT   = ACC_W + $clog2(AVG_SAMPLES);
    localparam int AVG_RECIP_W = ACC_W + 1;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
        AVG_RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

    localparam int PCT_SHIFT   = PROD_W + $clog2(PCT_BASE);
    localparam int PCT_RECIP_W = PCT_SHIFT - $clog2(PCT_BASE) + 1;
    localparam logic [PCT_RECIP_W-1:0] PCT_RECIP =
        PCT_RECIP_W'(((64'd1 << PCT_SHIFT) + 64'(PCT_BASE) - 64'd1) / 64'(PCT_BASE));

    localparam logic [2:0] REQ_SAMPLE       = 3'd0;
    localparam logic [2:0] REQ_RESTART      = 3'd1;
    localparam logic [2:0] REQ_TIMEOUT      = 3'd2;
    localparam logic [2:0] REQ_WRITE_STATUS = 3'd3;
    localparam logic [2:0] REQ_CLEAR_FLAG   = 3'd4;

    localparam logic [2:0] ST_START    = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_UNSTABLE = 3'd2;
    localparam logic [2:0] ST_STABLE   = 3'd3;
    localparam logic [2:0] ST_THROW    = 3'd4;

    localparam logic [1:0] CFG_SKIP_COUNT  = 2'd0;
    localparam logic [1:0] CFG_CHECK_COUNT = 2'd1;
    localparam logic [1:0] CFG_STABLE_PCT  = 2'd2;
    localparam logic [1:0] CFG_THROW_PCT   = 2'd3;

    typedef struct packed {
        logic [7:0] skip_count;
        logic [7:0] check_count;
        logic [6:0] stable_pct;
        logic [7:0] throw_pct;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [ACC_W-1:0] acc;
        logic [2:0]       status;
        logic             detect;
        logic [THR_W-1:0] thr;
    } mon_state_t;

    typedef struct packed {
        logic                   busy;
        logic                   avg_done;
        logic [PERIOD_BITS-1:0] avg_quot;
        logic [PERIOD_BITS-1:0] average;
        logic [BAND_W-1:0]      band_high;
        logic [PERIOD_BITS-1:0] band_low;
        logic [THR_W-1:0]       throw_off;
    } scale_t;

endpackage

>>> src/epsm_step.sv
module epsm_step (
    input  logic [2:0]                      req_type,
    input  logic [epsm_pkg::PERIOD_BITS-1:0] period,
    input  logic [15:0]                     count_value,
    input  logic [2:0]                      status_value,
    input  epsm_pkg::cfg_t                  cfg,
    input  epsm_pkg::scale_t                scl,
    input  epsm_pkg::mon_state_t            cur,
    output epsm_pkg::mon_state_t            nxt,
    output logic                            start_avg
);

    logic [epsm_pkg::CNT_W-1:0] cnt_inc;
    logic [epsm_pkg::CNT_W-1:0] skip_ext;
    logic [epsm_pkg::CNT_W-1:0] skip_first;
    logic [epsm_pkg::CNT_W-1:0] avg_end;
    logic [epsm_pkg::CNT_W-1:0] win_end;
    logic [7:0]                 chk;
    logic [epsm_pkg::ACC_W-1:0] run_inc;
    logic [epsm_pkg::ACC_W-1:0] p_acc;
    logic [epsm_pkg::BAND_W-1:0] p_band;
    logic [epsm_pkg::THR_W-1:0] p_thr;
    logic [epsm_pkg::THR_W-1:0] thr_new;

    always_comb begin
        cnt_inc    = (cur.cnt == epsm_pkg::CNT_MAX) ? cur.cnt
                                                   : cur.cnt + epsm_pkg::CNT_W'(1);
        chk        = (cfg.check_count == 8'd0) ? 8'd1 : cfg.check_count;
        skip_ext   = epsm_pkg::CNT_W'(cfg.skip_count);
        skip_first = skip_ext + epsm_pkg::CNT_W'(1);
        avg_end    = skip_ext + epsm_pkg::CNT_W'(epsm_pkg::AVG_SAMPLES);
        win_end    = avg_end + epsm_pkg::CNT_W'(chk);
        run_inc    = (cur.acc < epsm_pkg::ACC_W'(epsm_pkg::CNT_MAX))
                     ? cur.acc + epsm_pkg::ACC_W'(1) : cur.acc;
        p_acc      = epsm_pkg::ACC_W'(period);
        p_band     = epsm_pkg::BAND_W'(period);
        p_thr      = epsm_pkg::THR_W'(period);
        thr_new    = epsm_pkg::THR_W'(scl.average) + scl.throw_off;

        nxt       = cur;
        start_avg = 1'b0;

        unique case (req_type)
            epsm_pkg::REQ_SAMPLE: begin
                nxt.cnt = cnt_inc;
                if (cnt_inc > skip_ext) begin
                    priority if (cnt_inc <= avg_end) begin
                        nxt.acc   = (cnt_inc == skip_first) ? p_acc : cur.acc + p_acc;
                        start_avg = (cnt_inc == avg_end);
                    end else if (cnt_inc < win_end) begin
                        if (p_band > scl.band_high || period < scl.band_low) begin
                            nxt.status = epsm_pkg::ST_UNSTABLE;
                        end
                    end else if (cnt_inc == win_end) begin
                        nxt.status = epsm_pkg::ST_STABLE;
                        nxt.thr    = thr_new;
                        nxt.acc    = '0;
                    end else begin
                        if (p_thr >= cur.thr) begin
                            nxt.status = epsm_pkg::ST_THROW;
                            nxt.detect = 1'b1;
                            nxt.acc    = '0;
                        end else if (p_band < scl.band_high && period > scl.band_low) begin
                            nxt.acc = run_inc;
                            if (run_inc >= epsm_pkg::ACC_W'(chk)) begin
                                nxt.status = epsm_pkg::ST_STABLE;
                            end
                        end
                    end
                end
            end
            epsm_pkg::REQ_RESTART: begin
                nxt.cnt = count_value;
            end
            epsm_pkg::REQ_TIMEOUT: begin
                nxt.status = epsm_pkg::ST_TIMEOUT;
            end
            epsm_pkg::REQ_WRITE_STATUS: begin
                if (status_value <= epsm_pkg::ST_THROW) begin
                    nxt.status = status_value;
                end
            end
            epsm_pkg::REQ_CLEAR_FLAG: begin
                nxt.detect = 1'b0;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

>>> src/epsm_scale.sv
module epsm_scale (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start_avg,
    input  logic                       throw_restart,
    input  logic [epsm_pkg::ACC_W-1:0] acc,
    input  logic [6:0]                 stable_pct,
    input  logic [7:0]                 throw_pct,
    output epsm_pkg::scale_t           scl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_BMUL = 3'd2;
    localparam logic [2:0] S_BDIV = 3'd3;
    localparam logic [2:0] S_BSET = 3'd4;
    localparam logic [2:0] S_TMUL = 3'd5;
    localparam logic [2:0] S_TDIV = 3'd6;
    localparam logic [2:0] S_TSET = 3'd7;

    localparam int PB     = epsm_pkg::PERIOD_BITS;
    localparam int AVG_MW = epsm_pkg::ACC_W + epsm_pkg::AVG_RECIP_W;
    localparam int PCT_MW = epsm_pkg::PROD_W + epsm_pkg::PCT_RECIP_W;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [PB-1:0]                  average_reg;
    logic [epsm_pkg::BAND_W-1:0]    band_high_reg;
    logic [PB-1:0]                  band_low_reg;
    logic [epsm_pkg::THR_W-1:0]     throw_off_reg;
    logic [epsm_pkg::PROD_W-1:0]    prod_reg;
    logic [epsm_pkg::THR_W-1:0]     quot_reg;

    logic [AVG_MW-1:0]              avg_mult;
    logic [PCT_MW-1:0]              pct_mult;
    logic [PB-1:0]                  avg_quot;
    logic [epsm_pkg::THR_W-1:0]     pct_quot;
    logic [7:0]                     pct_sel;
    logic [epsm_pkg::BAND_W-1:0]    band_high_new;
    logic [PB-1:0]                  band_low_new;

    always_comb begin
        avg_mult = AVG_MW'(acc) * AVG_MW'(epsm_pkg::AVG_RECIP);
        avg_quot = avg_mult[epsm_pkg::AVG_SHIFT +: PB];
        pct_mult = PCT_MW'(prod_reg) * PCT_MW'(epsm_pkg::PCT_RECIP);
        pct_quot = pct_mult[epsm_pkg::PCT_SHIFT +: epsm_pkg::THR_W];
        pct_sel  = (state_reg == S_BMUL) ? {1'b0, stable_pct} : throw_pct;
        band_high_new = epsm_pkg::BAND_W'(average_reg) + quot_reg[epsm_pkg::BAND_W-1:0];
        band_low_new  = (quot_reg > epsm_pkg::THR_W'(average_reg))
                        ? '0 : average_reg - quot_reg[PB-1:0];
    end

    always_comb begin
        priority if (start_avg) begin
            state_next = S_DIV;
        end else if (throw_restart && (state_reg == S_IDLE || state_reg == S_TMUL ||
                                       state_reg == S_TDIV || state_reg == S_TSET)) begin
            state_next = S_TMUL;
        end else begin
            unique case (state_reg)
                S_IDLE:  state_next = S_IDLE;
                S_DIV:   state_next = S_BMUL;
                S_BMUL:  state_next = S_BDIV;
                S_BDIV:  state_next = S_BSET;
                S_BSET:  state_next = S_TMUL;
                S_TMUL:  state_next = S_TDIV;
                S_TDIV:  state_next = S_TSET;
                S_TSET:  state_next = S_IDLE;
                default: state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            average_reg   <= '0;
            band_high_reg <= '0;
            band_low_reg  <= '0;
            throw_off_reg <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                S_DIV:  average_reg <= avg_quot;
                S_BSET: begin
                    band_high_reg <= band_high_new;
                    band_low_reg  <= band_low_new;
                end
                S_TSET: throw_off_reg <= quot_reg;
                default: begin
                    average_reg <= average_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= epsm_pkg::PROD_W'(average_reg) * epsm_pkg::PROD_W'(pct_sel);
        quot_reg <= pct_quot;
    end

    assign scl.busy      = (state_reg != S_IDLE);
    assign scl.avg_done  = (state_reg == S_DIV);
    assign scl.avg_quot  = avg_quot;
    assign scl.average   = average_reg;
    assign scl.band_high = band_high_reg;
    assign scl.band_low  = band_low_reg;
    assign scl.throw_off = throw_off_reg;

endmodule

>>> src/encoder_period_stability_monitor.sv
// Results: each result passes the request register and is then registered in the output stage.
// The sample that completes the average is presented once the scaler's S_DIV state has formed
// the quotient, and the next transaction then waits while S_BMUL to S_TSET form the band and threshold.
// A throw_pct write holds input while S_TMUL, S_TDIV and S_TSET rebuild the threshold offset.
// Throughput: one transaction per cycle otherwise, set by the single request stage, unless m_ready stalls the output.
// Reset: aresetn is synchronous, active low; state clears to zero, config to defaults.
module encoder_period_stability_monitor (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [2:0]                       s_req_type,
    input  logic [epsm_pkg::PERIOD_BITS-1:0] s_period,
    input  logic [15:0]                      s_count_value,
    input  logic [2:0]                       s_status_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [2:0]                       m_status,
    output logic                             m_detect_flag,
    output logic [epsm_pkg::PERIOD_BITS-1:0] m_avg_period,
    output logic [epsm_pkg::THR_W-1:0]       m_throw_level,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [7:0]                       cfg_wdata
);

    logic                             in_valid_reg;
    logic [2:0]                       req_type_reg;
    logic [epsm_pkg::PERIOD_BITS-1:0] period_reg;
    logic [15:0]                      count_value_reg;
    logic [2:0]                       status_value_reg;

    epsm_pkg::cfg_t       cfg_reg;
    epsm_pkg::mon_state_t mon_reg;
    epsm_pkg::mon_state_t mon_next;
    epsm_pkg::scale_t     scl;

    logic                             m_valid_reg;
    logic [2:0]                       m_status_reg;
    logic                             m_detect_reg;
    logic [epsm_pkg::PERIOD_BITS-1:0] m_avg_reg;
    logic [epsm_pkg::THR_W-1:0]       m_thr_reg;

    logic out_free;
    logic advance;
    logic start_avg;
    logic load_out;
    logic throw_restart;

    assign out_free      = !m_valid_reg || m_ready;
    assign advance       = in_valid_reg && out_free && !scl.busy;
    assign load_out      = advance && !start_avg;
    assign s_ready       = !in_valid_reg || advance;
    assign throw_restart = cfg_we && (cfg_index == epsm_pkg::CFG_THROW_PCT);

    epsm_step u_step (
        .req_type     (req_type_reg),
        .period       (period_reg),
        .count_value  (count_value_reg),
        .status_value (status_value_reg),
        .cfg          (cfg_reg),
        .scl          (scl),
        .cur          (mon_reg),
        .nxt          (mon_next),
        .start_avg    (start_avg)
    );

    epsm_scale u_scale (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start_avg     (advance && start_avg),
        .throw_restart (throw_restart),
        .acc           (mon_reg.acc),
        .stable_pct    (cfg_reg.stable_pct),
        .throw_pct     (cfg_reg.throw_pct),
        .scl           (scl)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.skip_count  <= 8'd100;
            cfg_reg.check_count <= 8'd10;
            cfg_reg.stable_pct  <= 7'd10;
            cfg_reg.throw_pct   <= 8'd20;
        end else if (cfg_we) begin
            unique case (cfg_index)
                epsm_pkg::CFG_SKIP_COUNT:  cfg_reg.skip_count  <= cfg_wdata;
                epsm_pkg::CFG_CHECK_COUNT: cfg_reg.check_count <= cfg_wdata;
                epsm_pkg::CFG_STABLE_PCT:  cfg_reg.stable_pct  <= cfg_wdata[6:0];
                epsm_pkg::CFG_THROW_PCT:   cfg_reg.throw_pct   <= cfg_wdata;
                default:                   cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_type_reg     <= s_req_type;
            period_reg       <= s_period;
            count_value_reg  <= s_count_value;
            status_value_reg <= s_status_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mon_reg <= '0;
        end else if (advance) begin
            mon_reg <= mon_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            priority if (load_out || scl.avg_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        priority if (load_out) begin
            m_status_reg <= mon_next.status;
            m_detect_reg <= mon_next.detect;
            m_avg_reg    <= scl.average;
            m_thr_reg    <= mon_next.thr;
        end else if (scl.avg_done) begin
            m_status_reg <= mon_reg.status;
            m_detect_reg <= mon_reg.detect;
            m_avg_reg    <= scl.avg_quot;
            m_thr_reg    <= mon_reg.thr;
        end else begin
            m_status_reg <= m_status_reg;
            m_detect_reg <= m_detect_reg;
            m_avg_reg    <= m_avg_reg;
            m_thr_reg    <= m_thr_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_detect_flag = m_detect_reg;
    assign m_avg_period  = m_avg_reg;
    assign m_throw_level = m_thr_reg;

endmodule
